// File: rtl/ic_pkg.sv
package ic_pkg;

    localparam int IC_MAX_N       = 1024;
    localparam int IC_VALUE_WIDTH = 32;
    localparam int INV_W          = 19;
    localparam int ECNT_W         = 11;

    typedef struct packed {
        logic valid;
        logic last;
        logic drop;
        logic ovf;
    } t_tok_ctl;

endpackage

// File: rtl/ic_if.sv
interface ic_in_if #(
    parameter int VALUE_WIDTH = ic_pkg::IC_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface ic_out_if;
    logic                         valid;
    logic                         ready;
    logic [ic_pkg::INV_W-1:0]     inversions;
    logic [ic_pkg::ECNT_W-1:0]    element_count;
    logic                         overflow;

    modport source (output valid, output inversions, output element_count,
                    output overflow, input ready);
    modport sink   (input valid, input inversions, input element_count,
                    input overflow, output ready);
endinterface

// File: rtl/ic_cell.sv
module ic_cell #(
    parameter int VALUE_WIDTH = ic_pkg::IC_VALUE_WIDTH,
    parameter int CW          = 10,
    parameter int EW          = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  ic_pkg::t_tok_ctl              i_ctl,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic [CW-1:0]                 i_cnt,
    input  logic [EW-1:0]                 i_ecnt,
    output ic_pkg::t_tok_ctl              o_ctl,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic [CW-1:0]                 o_cnt,
    output logic [EW-1:0]                 o_ecnt
);
    import ic_pkg::*;

    logic                          r_full;
    logic                          n_full;
    logic signed [VALUE_WIDTH-1:0] r_stored;
    logic                          n_wr;
    logic [CW-1:0]                 n_cnt;
    t_tok_ctl                      r_ctl;
    t_tok_ctl                      n_ctl;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic [CW-1:0]                 r_cnt;
    logic [EW-1:0]                 r_ecnt;

    always_comb begin
        n_full = r_full;
        n_wr   = 1'b0;
        n_cnt  = i_cnt;
        n_ctl  = i_ctl;
        if (i_ctl.valid) begin
            if (r_full) begin
                if (!i_ctl.drop && (r_stored > i_value)) begin
                    n_cnt = i_cnt + CW'(1);
                end
                if (i_ctl.last) begin
                    n_full = 1'b0;
                end
            end else if (!i_ctl.drop && !i_ctl.last) begin
                n_full     = 1'b1;
                n_wr       = 1'b1;
                // settled word passes on without storing again
                n_ctl.drop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_ctl  <= '0;
        end else if (i_adv) begin
            r_full <= n_full;
            r_ctl  <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (n_wr) begin
                r_stored <= i_value;
            end
            r_value <= i_value;
            r_cnt   <= n_cnt;
            r_ecnt  <= i_ecnt;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_value = r_value;
    assign o_cnt   = r_cnt;
    assign o_ecnt  = r_ecnt;

endmodule

// File: rtl/ic_acc.sv
module ic_acc #(
    parameter int CW = 10,
    parameter int EW = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  ic_pkg::t_tok_ctl            i_ctl,
    input  logic [CW-1:0]               i_cnt,
    input  logic [EW-1:0]               i_ecnt,
    output logic                        o_valid,
    output logic [ic_pkg::INV_W-1:0]    o_inv,
    output logic [ic_pkg::ECNT_W-1:0]   o_ecnt,
    output logic                        o_ovf
);
    import ic_pkg::*;

    logic [INV_W-1:0]  r_total;
    logic [INV_W:0]    n_sum;
    logic [INV_W-1:0]  n_total;
    logic              r_valid;
    logic [INV_W-1:0]  r_inv;
    logic [ECNT_W-1:0] r_ecnt;
    logic              r_ovf;

    // saturate at the largest value the result field holds
    always_comb begin
        n_sum   = {1'b0, r_total} + (INV_W+1)'(i_cnt);
        n_total = n_sum[INV_W] ? {INV_W{1'b1}} : n_sum[INV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid && i_ctl.last;
            if (i_ctl.valid) begin
                r_total <= i_ctl.last ? '0 : n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.valid && i_ctl.last) begin
            r_inv  <= n_total;
            r_ecnt <= ECNT_W'(i_ecnt);
            r_ovf  <= i_ctl.ovf;
        end
    end

    assign o_valid = r_valid;
    assign o_inv   = r_inv;
    assign o_ecnt  = r_ecnt;
    assign o_ovf   = r_ovf;

endmodule

// File: rtl/inversion_counter.sv
// inversion_counter: counts pairs i<j with a[i] > a[j] over a sequence of
// signed words. Equal values do not count.
// Input channel i_in: one word per accepted element (value, last). The word
// flagged last closes the sequence. Output channel o_out: one word per
// sequence carrying inversions, element_count and overflow.
// Elements beyond MAX_N are dropped; overflow is then set in the result.
// Structure: a row of MAX_N cells. Each word moves one cell per cycle unless
// the row is stalled, is compared with the value held in every filled cell
// it passes and settles in the first empty cell. The last word empties the
// cells behind it, so a new sequence may follow in the very next cycle.
// Throughput: one word per cycle while the output is not stalled.
// Result: after the last word is accepted it passes through every cell of
// the row and then the output register, which holds the result.
// Stall: while a result waits in the output register and o_out.ready is
// low, the whole row holds and i_in.ready is low.
// Reset: cells empty, counts cleared, no result pending.
module inversion_counter #(
    parameter int MAX_N       = ic_pkg::IC_MAX_N,
    parameter int VALUE_WIDTH = ic_pkg::IC_VALUE_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ic_in_if.sink    i_in,
    ic_out_if.source o_out
);
    import ic_pkg::*;

    localparam int CW = (MAX_N > 2) ? $clog2(MAX_N) : 1;
    localparam int EW = $clog2(MAX_N + 1);

    logic                          adv;
    logic                          in_acc;
    logic                          full;
    logic [EW-1:0]                 r_count;
    logic                          r_ovf;
    t_tok_ctl                      inj_ctl;
    logic [EW-1:0]                 inj_ecnt;

    t_tok_ctl                      tok_ctl   [0:MAX_N];
    logic signed [VALUE_WIDTH-1:0] tok_value [0:MAX_N];
    logic [CW-1:0]                 tok_cnt   [0:MAX_N];
    logic [EW-1:0]                 tok_ecnt  [0:MAX_N];

    logic out_valid;

    assign adv         = !out_valid || o_out.ready;
    assign i_in.ready  = adv;
    assign in_acc      = i_in.valid && adv;
    assign full        = (r_count == EW'(MAX_N));

    always_comb begin
        inj_ctl.valid = in_acc && (!full || i_in.last);
        inj_ctl.last  = i_in.last;
        inj_ctl.drop  = full;
        inj_ctl.ovf   = r_ovf || full;
        inj_ecnt      = full ? r_count : r_count + EW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (in_acc) begin
            if (i_in.last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + EW'(1);
            end
        end
    end

    assign tok_ctl[0]   = inj_ctl;
    assign tok_value[0] = i_in.value;
    assign tok_cnt[0]   = '0;
    assign tok_ecnt[0]  = inj_ecnt;

    for (genvar g = 0; g < MAX_N; g++) begin : g_cell
        ic_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CW          (CW),
            .EW          (EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (tok_ctl[g]),
            .i_value (tok_value[g]),
            .i_cnt   (tok_cnt[g]),
            .i_ecnt  (tok_ecnt[g]),
            .o_ctl   (tok_ctl[g+1]),
            .o_value (tok_value[g+1]),
            .o_cnt   (tok_cnt[g+1]),
            .o_ecnt  (tok_ecnt[g+1])
        );
    end

    ic_acc #(
        .CW (CW),
        .EW (EW)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (tok_ctl[MAX_N]),
        .i_cnt   (tok_cnt[MAX_N]),
        .i_ecnt  (tok_ecnt[MAX_N]),
        .o_valid (out_valid),
        .o_inv   (o_out.inversions),
        .o_ecnt  (o_out.element_count),
        .o_ovf   (o_out.overflow)
    );

    assign o_out.valid = out_valid;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= EW'(MAX_N))
        else $error("element count beyond capacity");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> (r_count == '0) && !r_ovf)
        else $error("sequence state not cleared after last word");

    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.last && full) |=> r_ovf && full)
        else $error("dropped word did not raise overflow");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !o_out.ready) |=> $stable(r_count) && out_valid)
        else $error("row advanced while result stalled");

endmodule
